// ----- hdl/abtf2d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package abtf2d_pkg;

   localparam int DATA_W = 32;
   localparam int CNT_W  = 16;
   localparam int GAIN_W = 18;
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int DIFF_W = DATA_W + 1;

   typedef enum logic [1:0] {
      ACT_START   = 2'd0,
      ACT_PREDICT = 2'd1,
      ACT_UPDATE  = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef enum logic [19:0] {
      S_IDLE  = 20'h00001,
      S_P_MR  = 20'h00002,
      S_P_ARC = 20'h00004,
      S_P_AC  = 20'h00008,
      S_U_DEN = 20'h00010,
      S_U_CMM = 20'h00020,
      S_U_CMP = 20'h00040,
      S_U_DVA = 20'h00080,
      S_U_DVB = 20'h00100,
      S_U_MAR = 20'h00200,
      S_U_ARC = 20'h00400,
      S_U_AC  = 20'h00800,
      S_U_DVR = 20'h01000,
      S_U_WVR = 20'h02000,
      S_U_WVC = 20'h04000,
      S_Q_MA  = 20'h08000,
      S_Q_MB  = 20'h10000,
      S_Q_SUM = 20'h20000,
      S_Q_SQ  = 20'h40000,
      S_DONE  = 20'h80000
   } state_type;

   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(32'h7FFF_FFFF);
   localparam logic signed [PROD_W-1:0] SAT_MIN = {{(PROD_W-31){1'b1}}, 31'b0};

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/alpha_beta_track_filter_2d_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Two-dimensional alpha-beta tracker, fixed point with FRAC_BITS fraction bits. One item
// at a time: req_tready is high only when idle, and every item returns exactly one result.
// All products go through one shared 34x34 multiplier, quotients through a shared
// restoring divider (one quotient bit per cycle, NW = max(18, FRAC_BITS+1) + 34 bits,
// 52 at the default), and the query distance through a two-bits-per-cycle square root.
// An update takes two gain quotients when the gains are still opening and two velocity
// quotients when dt > 0.
module alpha_beta_track_filter_2d_unit #(
   parameter int FRAC_BITS      = 16,
   parameter int OPEN_COUNT_MAX = 65535
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // dt, meas_row, meas_col
   input  wire logic [1:0]   req_tuser,   // action
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata,   // est_row, est_col, rate_row, rate_col, residual_mag
   output logic [1:0]        rsp_tuser,   // gain_fault, opening
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [2:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import abtf2d_pkg::*;

   localparam int GW  = (FRAC_BITS + 1 > GAIN_W) ? FRAC_BITS + 1 : GAIN_W;
   localparam int NW  = GW + DIFF_W + 1;
   localparam int DCW = $clog2(NW + 1);
   localparam int FW  = (FRAC_BITS + 3 > GAIN_W + 2) ? FRAC_BITS + 3 : GAIN_W + 2;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [NW-1:0] SIX_SH = NW'(6) << FRAC_BITS;
   localparam logic [FW-1:0] FOUR_SH = FW'(4) << FRAC_BITS;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(OPEN_COUNT_MAX);
   localparam logic REG_ALPHA = 1'b0;
   localparam logic REG_BETA  = 1'b1;

   state_type state_ff, state_in;
   action_type act_ff, act_in, req_act;
   logic signed [DATA_W-1:0] dt_ff, dt_in;
   logic signed [DIFF_W-1:0] rr_row_ff, rr_row_in, rr_col_ff, rr_col_in;
   logic signed [DATA_W-1:0] pos_row_ff, pos_row_in, pos_col_ff, pos_col_in;
   logic signed [DATA_W-1:0] vel_row_ff, vel_row_in, vel_col_ff, vel_col_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [GW-1:0] alpha_ff, alpha_in, beta_ff, beta_in;
   logic [DIFF_W-1:0] den_ff, den_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [DIFF_W-1:0] div_rem_ff, div_rem_in, div_den_ff, div_den_in;
   logic [NW-1:0] div_quo_ff, div_quo_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic sign_ff, sign_in;
   logic [63:0] sq_x_ff, sq_x_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [DATA_W-1:0] mag_ff, mag_in;
   logic fault_ff, fault_in, opened_ff, opened_in;
   logic [GAIN_W-1:0] cfg_alpha_ff, cfg_alpha_in, cfg_beta_ff, cfg_beta_in;

   // shared multiplier
   logic mul_en;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;
   // shared divider
   logic div_go;
   logic [NW-1:0] div_num;
   logic [DIFF_W-1:0] div_dsr;
   logic [DIFF_W:0] div_sh;
   logic div_ge;

   logic fault;
   logic signed [DATA_W-1:0] in_dt, in_mr, in_mc;
   logic signed [DIFF_W-1:0] dr, dc;
   logic [16:0] n_w;
   logic [NW-1:0] anum_sh;
   logic signed [DATA_W-1:0] pos_sel, vel_sel;
   logic signed [PROD_W-1:0] rnd, pos_sum, pmag, q_ext, vd, vel_sum;
   logic signed [DATA_W-1:0] pos_new, vel_new;
   logic [NW-1:0] vel_num;
   logic [64:0] sq_sum;
   logic [63:0] sq_t;
   logic cfg_wr;

   assign in_dt = req_tdata[31:0];
   assign in_mr = req_tdata[63:32];
   assign in_mc = req_tdata[95:64];
   assign req_act = action_type'(req_tuser);

   assign fault = (cfg_alpha_ff == '0) || (cfg_beta_ff == '0) ||
                  ((FW'(cfg_beta_ff) + (FW'(cfg_alpha_ff) << 1)) >= FOUR_SH);

   assign dr = DIFF_W'(in_mr) - DIFF_W'(pos_row_ff);
   assign dc = DIFF_W'(in_mc) - DIFF_W'(pos_col_ff);

   assign n_w = {1'b0, count_ff} + 17'd1;
   assign anum_sh = NW'(({2'b0, n_w} << 2) - 19'd2) << FRAC_BITS;

   assign mul_p = mul_a * mul_b;

   // position: round to nearest, ties up, then add and saturate
   assign pos_sel = (state_ff == S_P_ARC || state_ff == S_U_ARC) ? pos_row_ff : pos_col_ff;
   assign rnd = (prod_ff + HALF) >>> FRAC_BITS;
   assign pos_sum = rnd + PROD_W'(pos_sel);
   assign pos_new = sat32(pos_sum);

   // velocity: sign-magnitude quotient, ties away from zero via +dt/2
   assign pmag = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign vel_num = NW'(pmag) + NW'(dt_ff[DATA_W-1:1]);
   assign vel_sel = (state_ff == S_U_WVR) ? vel_row_ff : vel_col_ff;
   assign q_ext = PROD_W'(div_quo_ff);
   assign vd = sign_ff ? -q_ext : q_ext;
   assign vel_sum = vd + PROD_W'(vel_sel);
   assign vel_new = sat32(vel_sum);

   assign div_sh = {div_rem_ff, div_quo_ff[NW-1]};
   assign div_ge = div_sh >= {1'b0, div_den_ff};

   assign sq_sum = {1'b0, sq_x_ff} + {1'b0, prod_ff[63:0]};
   assign sq_t = sq_res_ff + sq_bit_ff;

   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      state_in = state_ff;
      act_in = act_ff;
      dt_in = dt_ff;
      rr_row_in = rr_row_ff;
      rr_col_in = rr_col_ff;
      pos_row_in = pos_row_ff;
      pos_col_in = pos_col_ff;
      vel_row_in = vel_row_ff;
      vel_col_in = vel_col_ff;
      count_in = count_ff;
      alpha_in = alpha_ff;
      beta_in = beta_ff;
      den_in = den_ff;
      prod_in = prod_ff;
      sign_in = sign_ff;
      sq_x_in = sq_x_ff;
      sq_res_in = sq_res_ff;
      sq_bit_in = sq_bit_ff;
      mag_in = mag_ff;
      fault_in = fault_ff;
      opened_in = opened_ff;
      mul_en = 1'b0;
      mul_a = '0;
      mul_b = '0;
      div_go = 1'b0;
      div_num = '0;
      div_dsr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               act_in = req_act;
               dt_in = in_dt;
               fault_in = fault;
               opened_in = 1'b0;
               mag_in = '0;
               if (req_act == ACT_QUERY) begin
                  rr_row_in = dr[DIFF_W-1] ? -dr : dr;
                  rr_col_in = dc[DIFF_W-1] ? -dc : dc;
               end else begin
                  rr_row_in = dr;
                  rr_col_in = dc;
               end
               unique case (req_act)
                  ACT_START: begin
                     if (!fault) begin
                        pos_row_in = in_mr;
                        pos_col_in = in_mc;
                        vel_row_in = '0;
                        vel_col_in = '0;
                        count_in = CNT_W'(1);
                     end
                     state_in = S_DONE;
                  end
                  ACT_PREDICT: state_in = S_P_MR;
                  ACT_UPDATE:  state_in = S_U_DEN;
                  ACT_QUERY:   state_in = S_Q_MA;
                  default:     state_in = S_DONE;
               endcase
            end
         end
         S_P_MR: begin
            mul_en = 1'b1;
            mul_a = MUL_W'(vel_row_ff);
            mul_b = MUL_W'(dt_ff);
            state_in = S_P_ARC;
         end
         S_P_ARC: begin
            pos_row_in = pos_new;
            mul_en = 1'b1;
            mul_a = MUL_W'(vel_col_ff);
            mul_b = MUL_W'(dt_ff);
            state_in = S_P_AC;
         end
         S_P_AC: begin
            pos_col_in = pos_new;
            state_in = S_DONE;
         end
         S_U_DEN: begin
            mul_en = 1'b1;
            mul_a = MUL_W'(n_w);
            mul_b = MUL_W'({1'b0, n_w} + 18'd1);
            state_in = S_U_CMM;
         end
         S_U_CMM: begin
            den_in = prod_ff[DIFF_W-1:0];
            mul_en = 1'b1;
            mul_a = MUL_W'(cfg_alpha_ff);
            mul_b = MUL_W'(prod_ff[DIFF_W-1:0]);
            state_in = S_U_CMP;
         end
         S_U_CMP: begin
            // exact compare of expanding alpha against the steady one
            if (PROD_W'(anum_sh) > $unsigned(prod_ff)) begin
               opened_in = 1'b1;
               div_go = 1'b1;
               div_num = anum_sh + NW'(den_ff[DIFF_W-1:1]);
               div_dsr = den_ff;
               state_in = S_U_DVA;
            end else begin
               alpha_in = GW'(cfg_alpha_ff);
               beta_in = GW'(cfg_beta_ff);
               state_in = S_U_MAR;
            end
         end
         S_U_DVA: begin
            if (div_cnt_ff == '0) begin
               alpha_in = div_quo_ff[GW-1:0];
               div_go = 1'b1;
               div_num = SIX_SH + NW'(den_ff[DIFF_W-1:1]);
               div_dsr = den_ff;
               state_in = S_U_DVB;
            end
         end
         S_U_DVB: begin
            if (div_cnt_ff == '0) begin
               beta_in = div_quo_ff[GW-1:0];
               if (count_ff < CNT_MAX) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = S_U_MAR;
            end
         end
         S_U_MAR: begin
            mul_en = 1'b1;
            mul_a = MUL_W'(alpha_ff);
            mul_b = MUL_W'(rr_row_ff);
            state_in = S_U_ARC;
         end
         S_U_ARC: begin
            pos_row_in = pos_new;
            mul_en = 1'b1;
            mul_a = MUL_W'(alpha_ff);
            mul_b = MUL_W'(rr_col_ff);
            state_in = S_U_AC;
         end
         S_U_AC: begin
            pos_col_in = pos_new;
            mul_en = 1'b1;
            mul_a = MUL_W'(beta_ff);
            mul_b = MUL_W'(rr_row_ff);
            state_in = (dt_ff > 0) ? S_U_DVR : S_DONE;
         end
         S_U_DVR: begin
            div_go = 1'b1;
            div_num = vel_num;
            div_dsr = DIFF_W'(dt_ff);
            sign_in = prod_ff[PROD_W-1];
            mul_en = 1'b1;
            mul_a = MUL_W'(beta_ff);
            mul_b = MUL_W'(rr_col_ff);
            state_in = S_U_WVR;
         end
         S_U_WVR: begin
            if (div_cnt_ff == '0) begin
               vel_row_in = vel_new;
               div_go = 1'b1;
               div_num = vel_num;
               div_dsr = DIFF_W'(dt_ff);
               sign_in = prod_ff[PROD_W-1];
               state_in = S_U_WVC;
            end
         end
         S_U_WVC: begin
            if (div_cnt_ff == '0) begin
               vel_col_in = vel_new;
               state_in = S_DONE;
            end
         end
         S_Q_MA: begin
            mul_en = 1'b1;
            mul_a = MUL_W'(rr_row_ff);
            mul_b = MUL_W'(rr_row_ff);
            state_in = S_Q_MB;
         end
         S_Q_MB: begin
            sq_x_in = prod_ff[63:0];
            mul_en = 1'b1;
            mul_a = MUL_W'(rr_col_ff);
            mul_b = MUL_W'(rr_col_ff);
            state_in = S_Q_SUM;
         end
         S_Q_SUM: begin
            if (sq_sum[64]) begin
               mag_in = '1;
               state_in = S_DONE;
            end else begin
               sq_x_in = sq_sum[63:0];
               sq_res_in = '0;
               sq_bit_in = 64'h4000_0000_0000_0000;
               state_in = S_Q_SQ;
            end
         end
         S_Q_SQ: begin
            if (sq_bit_ff != '0) begin
               if (sq_x_ff >= sq_t) begin
                  sq_x_in = sq_x_ff - sq_t;
                  sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_in = sq_res_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
            end else begin
               mag_in = sq_res_ff[DATA_W-1:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (mul_en) begin
         prod_in = mul_p;
      end
   end

   // divider: load, else one restoring step per cycle while the count runs
   always_comb begin
      div_rem_in = div_rem_ff;
      div_quo_in = div_quo_ff;
      div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      if (div_go) begin
         div_rem_in = '0;
         div_quo_in = div_num;
         div_den_in = div_dsr;
         div_cnt_in = DCW'(NW);
      end else if (div_cnt_ff != '0) begin
         div_rem_in = div_ge ? DIFF_W'(div_sh - {1'b0, div_den_ff}) : div_sh[DIFF_W-1:0];
         div_quo_in = {div_quo_ff[NW-2:0], div_ge};
         div_cnt_in = div_cnt_ff - DCW'(1);
      end
   end

   always_comb begin
      cfg_alpha_in = cfg_alpha_ff;
      cfg_beta_in = cfg_beta_ff;
      if (cfg_wr) begin
         if (csr_paddr[2] == REG_ALPHA) begin
            cfg_alpha_in = csr_pwdata[GAIN_W-1:0];
         end else begin
            cfg_beta_in = csr_pwdata[GAIN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_row_ff <= '0;
         pos_col_ff <= '0;
         vel_row_ff <= '0;
         vel_col_ff <= '0;
         count_ff <= CNT_W'(1);
         div_cnt_ff <= '0;
         cfg_alpha_ff <= GAIN_W'(32768);
         cfg_beta_ff <= GAIN_W'(16384);
      end else begin
         state_ff <= state_in;
         pos_row_ff <= pos_row_in;
         pos_col_ff <= pos_col_in;
         vel_row_ff <= vel_row_in;
         vel_col_ff <= vel_col_in;
         count_ff <= count_in;
         div_cnt_ff <= div_cnt_in;
         cfg_alpha_ff <= cfg_alpha_in;
         cfg_beta_ff <= cfg_beta_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff <= act_in;
      dt_ff <= dt_in;
      rr_row_ff <= rr_row_in;
      rr_col_ff <= rr_col_in;
      alpha_ff <= alpha_in;
      beta_ff <= beta_in;
      den_ff <= den_in;
      prod_ff <= prod_in;
      div_rem_ff <= div_rem_in;
      div_quo_ff <= div_quo_in;
      div_den_ff <= div_den_in;
      sign_ff <= sign_in;
      sq_x_ff <= sq_x_in;
      sq_res_ff <= sq_res_in;
      sq_bit_ff <= sq_bit_in;
      mag_ff <= mag_in;
      fault_ff <= fault_in;
      opened_ff <= opened_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_DONE);
   assign rsp_tdata = {mag_ff, vel_col_ff, vel_row_ff, pos_col_ff, pos_row_ff};
   assign rsp_tuser = {opened_ff, fault_ff};

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BETA) ? 32'(cfg_beta_ff) : 32'(cfg_alpha_ff);

   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input and result sides active together");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CNT_MAX)
      else $error("opening count out of range");

   a_open_update: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> act_ff == ACT_UPDATE)
      else $error("opening flag on a non-update result");

   a_div_idle_sqrt: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_Q_SQ |-> div_cnt_ff == '0)
      else $error("divider running during square root");

   a_vel_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_U_WVC && div_cnt_ff == '0 |=> state_ff == S_DONE)
      else $error("velocity update did not finish");

endmodule
`default_nettype wire

// ----- dv/alpha_beta_track_filter_2d_unit_tb.sv -----
`timescale 1ns / 1ps
module alpha_beta_track_filter_2d_unit_tb;
   import abtf2d_pkg::*;

   localparam int REG_STEADY_ALPHA = 0;
   localparam int REG_STEADY_BETA  = 1;
   localparam longint FRAC = 16;
   localparam longint COUNT_CAP = 65535;
   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 400;

   typedef struct {
      logic [31:0] est_row;
      logic [31:0] est_col;
      logic [31:0] rate_row;
      logic [31:0] rate_col;
      logic [31:0] residual_mag;
      logic        gain_fault;
      logic        opening;
   } track_result_type;

   class track_scoreboard;
      longint alpha_gain, beta_gain;
      longint row_pos, col_pos, row_vel, col_vel, open_cnt;
      track_result_type pending_estimates[$];
      int fails;

      function new();
         alpha_gain = 32768;
         beta_gain  = 16384;
         row_pos = 0; col_pos = 0; row_vel = 0; col_vel = 0;
         open_cnt = 1;
         fails = 0;
      endfunction

      function void set_gain(int idx, logic [31:0] value);
         if (idx == REG_STEADY_ALPHA) alpha_gain = longint'(value[17:0]);
         else beta_gain = longint'(value[17:0]);
      endfunction

      function longint clip_q16(longint v);
         if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
         if (v < -64'sh8000_0000) return -64'sh8000_0000;
         return v;
      endfunction

      // round to nearest, ties toward +inf; >>> on signed is floor
      function longint round_q16(longint v);
         longint t;
         t = v + (64'sd1 <<< (FRAC - 1));
         return t >>> FRAC;
      endfunction

      function longint vel_adjust(longint vel, longint gain, longint resid, longint dt);
         longint num, mag, q;
         num = gain * resid;
         mag = (num < 0) ? -num : num;
         q = (mag + dt / 2) / dt;
         return clip_q16(vel + ((num < 0) ? -q : q));
      endfunction

      function longint unsigned int_sqrt(longint unsigned x);
         longint unsigned res, bitv;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= res + bitv) begin
               x -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function void note_item(action_type act, logic [31:0] dt_bits,
                              logic [31:0] mr_bits, logic [31:0] mc_bits);
         track_result_type r;
         longint dt, mr, mc, n, den, anum, al, be, rr, rc, da, db;
         logic [65:0] sq;
         logic fault;
         logic [31:0] mag;
         dt = longint'(signed'(dt_bits));
         mr = longint'(signed'(mr_bits));
         mc = longint'(signed'(mc_bits));
         fault = (alpha_gain == 0) || (beta_gain == 0) ||
                 (beta_gain + 2 * alpha_gain >= (64'sd4 <<< FRAC));
         mag = 0;
         r.opening = 0;
         case (act)
            ACT_START: begin
               if (!fault) begin
                  row_pos = mr; col_pos = mc; row_vel = 0; col_vel = 0; open_cnt = 1;
               end
            end
            ACT_PREDICT: begin
               row_pos = clip_q16(row_pos + round_q16(row_vel * dt));
               col_pos = clip_q16(col_pos + round_q16(col_vel * dt));
            end
            ACT_UPDATE: begin
               n = open_cnt + 1;
               den = n * (n + 1);
               anum = 2 * (2 * n - 1);
               al = alpha_gain; be = beta_gain;
               rr = mr - row_pos; rc = mc - col_pos;
               if ((anum <<< FRAC) > alpha_gain * den) begin
                  r.opening = 1;
                  al = ((anum <<< FRAC) + den / 2) / den;
                  be = ((64'sd6 <<< FRAC) + den / 2) / den;
                  if (open_cnt < COUNT_CAP) open_cnt++;
               end
               row_pos = clip_q16(row_pos + round_q16(al * rr));
               col_pos = clip_q16(col_pos + round_q16(al * rc));
               if (dt > 0) begin
                  row_vel = vel_adjust(row_vel, be, rr, dt);
                  col_vel = vel_adjust(col_vel, be, rc, dt);
               end
            end
            default: begin
               da = mr - row_pos; db = mc - col_pos;
               if (da < 0) da = -da;
               if (db < 0) db = -db;
               if (da >= 64'sh1_0000_0000 || db >= 64'sh1_0000_0000) begin
                  mag = 32'hFFFF_FFFF;
               end else begin
                  sq = 66'(da) * 66'(da) + 66'(db) * 66'(db);
                  if (sq[65:64] != 0) mag = 32'hFFFF_FFFF;
                  else mag = 32'(int_sqrt(sq[63:0]));
               end
            end
         endcase
         r.est_row = row_pos[31:0];
         r.est_col = col_pos[31:0];
         r.rate_row = row_vel[31:0];
         r.rate_col = col_vel[31:0];
         r.residual_mag = mag;
         r.gain_fault = fault;
         pending_estimates.push_back(r);
      endfunction

      function void check_result(track_result_type got);
         track_result_type e;
         if (pending_estimates.size() == 0) begin
            $display("%0t: unexpected result est_row=%h est_col=%h", $time,
                     got.est_row, got.est_col);
            fails++;
            return;
         end
         e = pending_estimates.pop_front();
         if (got.est_row !== e.est_row) begin
            $display("%0t: est_row exp %h got %h", $time, e.est_row, got.est_row); fails++;
         end
         if (got.est_col !== e.est_col) begin
            $display("%0t: est_col exp %h got %h", $time, e.est_col, got.est_col); fails++;
         end
         if (got.rate_row !== e.rate_row) begin
            $display("%0t: rate_row exp %h got %h", $time, e.rate_row, got.rate_row); fails++;
         end
         if (got.rate_col !== e.rate_col) begin
            $display("%0t: rate_col exp %h got %h", $time, e.rate_col, got.rate_col); fails++;
         end
         if (got.residual_mag !== e.residual_mag) begin
            $display("%0t: residual_mag exp %h got %h", $time, e.residual_mag,
                     got.residual_mag);
            fails++;
         end
         if (got.gain_fault !== e.gain_fault) begin
            $display("%0t: gain_fault exp %b got %b", $time, e.gain_fault, got.gain_fault);
            fails++;
         end
         if (got.opening !== e.opening) begin
            $display("%0t: opening exp %b got %b", $time, e.opening, got.opening); fails++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [95:0] req_tdata = '0;   // dt, meas_row, meas_col
   logic [1:0] req_tuser = '0;    // action
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [159:0] rsp_tdata;       // est_row, est_col, rate_row, rate_col, residual_mag
   logic [1:0] rsp_tuser;         // gain_fault, opening
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   track_scoreboard sb = new();
   bit no_idle = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   alpha_beta_track_filter_2d_unit u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         stall_left <= no_idle ? 0 : $urandom_range(0, 9);
         rsp_tready <= no_idle || ($urandom_range(0, 9) == 0);
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   always @(posedge clock) begin
      track_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.est_row = rsp_tdata[31:0];
         got.est_col = rsp_tdata[63:32];
         got.rate_row = rsp_tdata[95:64];
         got.rate_col = rsp_tdata[127:96];
         got.residual_mag = rsp_tdata[159:128];
         got.gain_fault = rsp_tuser[0];
         got.opening = rsp_tuser[1];
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(action_type act, logic [31:0] dt,
                            logic [31:0] mr, logic [31:0] mc);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= act;
      req_tdata <= {mc, mr, dt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_item(act, dt, mr, mc);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (sb.pending_estimates.size() != 0) @(posedge clock);
      // quiet stretch before the next configuration write
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_gain(int idx, logic [31:0] value);
      csr_psel <= 1;
      csr_pwrite <= 1;
      csr_penable <= 0;
      csr_paddr <= 3'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      sb.set_gain(idx, value);
   endtask

   function automatic logic [31:0] pick_coord();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
      if (sel < 9) return 32'($signed($urandom_range(0, 2 * 268435456)) - 268435456);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_step();
      int sel;
      sel = $urandom_range(0, 19);
      if (sel < 12) return $urandom_range(1, 131072);
      if (sel < 15) return 32'(-$signed($urandom_range(0, 65536)));
      return $urandom;
   endfunction

   task automatic random_track(int count);
      int sel;
      action_type act;
      send_item(ACT_START, $urandom, pick_coord(), pick_coord());
      repeat (count) begin
         sel = $urandom_range(0, 99);
         act = (sel < 6) ? ACT_START : (sel < 30) ? ACT_PREDICT :
               (sel < 75) ? ACT_UPDATE : ACT_QUERY;
         send_item(act, pick_step(), pick_coord(), pick_coord());
      end
   endtask

   initial begin
      logic [31:0] alpha_set[6];
      logic [31:0] beta_set[6];
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, saturation, non-positive step
      send_item(ACT_PREDICT, 32'h7FFF_FFFF, 0, 0);
      send_item(ACT_START, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(ACT_QUERY, 0, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(ACT_QUERY, 0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(ACT_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(ACT_UPDATE, 1, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(ACT_PREDICT, 32'h7FFF_FFFF, 0, 0);
      send_item(ACT_PREDICT, 32'h8000_0000, 0, 0);
      send_item(ACT_START, 32'hFFFF_FFFF, 0, 0);
      send_item(ACT_UPDATE, 0, 32'h0001_0000, 32'hFFFF_0000);
      send_item(ACT_UPDATE, 32'h8000_0000, 32'h0002_0000, 32'hFFFE_0000);
      send_item(ACT_UPDATE, 32'h0001_0000, 32'h0003_0000, 32'hFFFD_0000);
      send_item(ACT_PREDICT, 32'h0000_8000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(ACT_QUERY, 32'hFFFF_FFFF, 0, 0);
      send_item(ACT_QUERY, 0, 32'h0003_0000, 32'hFFFD_0000);
      drain();
      // faulty gains: start rejected, others still run
      write_gain(REG_STEADY_ALPHA, 32'd131072);
      write_gain(REG_STEADY_BETA, 32'd1);
      send_item(ACT_START, 0, 32'h0010_0000, 32'h0010_0000);
      send_item(ACT_UPDATE, 32'h0001_0000, 32'h0010_0000, 32'h0010_0000);
      send_item(ACT_PREDICT, 32'h0001_0000, 0, 0);
      send_item(ACT_QUERY, 0, 0, 0);
      drain();

      alpha_set = '{32768, 1, 262143, 65536, 100000, 131071};
      beta_set  = '{16384, 1, 262143, 65536, 50000, 1};
      for (int p = 0; p < 6; p++) begin
         write_gain(REG_STEADY_ALPHA, alpha_set[p]);
         write_gain(REG_STEADY_BETA, beta_set[p]);
         no_idle = (p % 3 == 2);
         for (int t = 0; t < 10; t++) random_track(29);
         drain();
      end
      no_idle = 0;

      if (sb.fails == 0 && sb.pending_estimates.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule

// ----- alpha_beta_track_filter_2d_unit.f -----
hdl/abtf2d_pkg.sv
hdl/alpha_beta_track_filter_2d_unit.sv
dv/alpha_beta_track_filter_2d_unit_tb.sv
